/* rtl/lse_pkg.sv */
// Shared operation codes, status codes and field widths of the LIFO stack engine.
package lse_pkg;

  localparam int unsigned OpWidth     = 2;
  localparam int unsigned ValueWidth  = 32;
  localparam int unsigned StatusWidth = 2;
  localparam int unsigned CountWidth  = 7;

  localparam logic [OpWidth-1:0] OP_PUSH = 2'd0;
  localparam logic [OpWidth-1:0] OP_POP  = 2'd1;
  localparam logic [OpWidth-1:0] OP_PEEK = 2'd2;
  localparam logic [OpWidth-1:0] OP_DUMP = 2'd3;

  localparam logic [StatusWidth-1:0] ST_OK    = 2'd0;
  localparam logic [StatusWidth-1:0] ST_EMPTY = 2'd1;
  localparam logic [StatusWidth-1:0] ST_FULL  = 2'd2;

  typedef logic signed [ValueWidth-1:0] value_t;

endpackage

/* rtl/lse_in_if.sv */
// Command channel of the LIFO stack engine: one operation per transfer.
interface lse_in_if;
  logic                           valid;
  logic                           ready;
  logic [lse_pkg::OpWidth-1:0]    op;
  lse_pkg::value_t                push_value;

  modport source (output valid, output op, output push_value, input ready);
  modport sink   (input valid, input op, input push_value, output ready);
endinterface

/* rtl/lse_out_if.sv */
// Result channel of the LIFO stack engine: one result item per transfer.
interface lse_out_if;
  logic                              valid;
  logic                              ready;
  logic [lse_pkg::StatusWidth-1:0]   status;
  lse_pkg::value_t                   entry_value;
  logic [lse_pkg::CountWidth-1:0]    entry_count;
  logic                              is_empty;
  logic                              last_of_run;

  modport source (output valid, output status, output entry_value, output entry_count,
                  output is_empty, output last_of_run, input ready);
  modport sink   (input valid, input status, input entry_value, input entry_count,
                  input is_empty, input last_of_run, output ready);
endinterface

/* rtl/lifo_stack_engine.sv */
// Bounded LIFO stack of signed 32-bit values with push, pop, peek and dump.
//
// The cmd channel takes one operation per transfer (push, pop, peek, dump).
// The res channel returns one result per push, pop and peek, and one result
// per stored entry for a dump, top entry first, with last_of_run on the final
// one. Every result carries the entry count after the operation and an empty
// flag. Pop, peek and dump on an empty stack give status empty; a push onto a
// full stack is refused with status full.
// Entries live in a single-port-write, registered-read memory of STACK_DEPTH
// words. Push and any refused or empty operation give their result in the
// cycle after the transfer and a new command may follow at once. Pop and peek
// read the memory first; the data comes from a read state that holds off the
// next command. A dump of N entries streams N results, one per cycle unless
// res stalls, and takes no new command until its last result is registered.
// A stall on res holds the registered result and blocks further commands; the
// result register is released and refilled in the same cycle it is taken.
// Reset (rst, synchronous) empties the stack and drops any pending result;
// the memory itself is not cleared.
module lifo_stack_engine #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst,
  lse_in_if.sink    cmd,
  lse_out_if.source res
);

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_DUMP = 2'd2;

  lse_pkg::value_t mem [STACK_DEPTH];
  lse_pkg::value_t rd_data;

  logic [1:0]    state, state_next;
  logic [CW-1:0] count, count_next;
  logic [AW-1:0] dump_idx, dump_idx_next;

  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [CW-1:0] cnt_dec;
  logic [AW-1:0] top_addr;
  logic          full, empty, out_free;

  logic                               load_out;
  logic [lse_pkg::StatusWidth-1:0]    ld_status;
  lse_pkg::value_t                    ld_value;
  logic                               ld_last;

  assign cnt_dec   = count - CW'(1);
  assign top_addr  = cnt_dec[AW-1:0];
  assign full      = (count == CW'(STACK_DEPTH));
  assign empty     = (count == '0);
  assign out_free  = !res.valid || res.ready;
  assign cmd.ready = (state == S_IDLE) && out_free;

  always_comb begin
    state_next    = state;
    count_next    = count;
    dump_idx_next = dump_idx;
    wr_en         = 1'b0;
    wr_addr       = count[AW-1:0];
    rd_en         = 1'b0;
    rd_addr       = top_addr;
    load_out      = 1'b0;
    ld_status     = lse_pkg::ST_OK;
    ld_value      = '0;
    ld_last       = 1'b1;
    case (state)
      S_IDLE: begin
        if (cmd.valid && cmd.ready) begin
          case (cmd.op)
            lse_pkg::OP_PUSH: begin
              load_out = 1'b1;
              if (full) begin
                ld_status = lse_pkg::ST_FULL;
              end else begin
                wr_en      = 1'b1;
                count_next = count + CW'(1);
              end
            end
            lse_pkg::OP_POP, lse_pkg::OP_PEEK, lse_pkg::OP_DUMP: begin
              if (empty) begin
                load_out  = 1'b1;
                ld_status = lse_pkg::ST_EMPTY;
              end else begin
                rd_en = 1'b1;
                if (cmd.op == lse_pkg::OP_POP) begin
                  count_next = cnt_dec;
                end
                if (cmd.op == lse_pkg::OP_DUMP) begin
                  dump_idx_next = top_addr;
                  state_next    = S_DUMP;
                end else begin
                  state_next = S_READ;
                end
              end
            end
            default: begin
              load_out = 1'b0;
            end
          endcase
        end
      end
      S_READ: begin
        if (out_free) begin
          load_out   = 1'b1;
          ld_value   = rd_data;
          state_next = S_IDLE;
        end
      end
      S_DUMP: begin
        if (out_free) begin
          load_out = 1'b1;
          ld_value = rd_data;
          ld_last  = (dump_idx == '0);
          if (dump_idx == '0) begin
            state_next = S_IDLE;
          end else begin
            // Fetch the next lower entry while this one is handed over.
            rd_en         = 1'b1;
            rd_addr       = dump_idx - AW'(1);
            dump_idx_next = dump_idx - AW'(1);
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= cmd.push_value;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      dump_idx  <= '0;
      res.valid <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      dump_idx <= dump_idx_next;
      if (load_out) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      res.status      <= ld_status;
      res.entry_value <= ld_value;
      res.entry_count <= lse_pkg::CountWidth'(count_next);
      res.is_empty    <= (count_next == '0);
      res.last_of_run <= ld_last;
    end
  end

endmodule

/* dv/lifo_stack_engine_tb.sv */
// Self-checking testbench for the LIFO stack engine: directed and random command streams.
module lifo_stack_engine_tb;

  localparam int unsigned DEPTH       = 64;
  localparam int          HOLD_CYCLES = 200;
  localparam int          QUIET_TAIL  = 20;
  localparam int          DRAIN_WAIT  = 10;
  localparam int          STALL_LIMIT = 1500;

  typedef struct {
    logic [lse_pkg::OpWidth-1:0] op;
    lse_pkg::value_t             value;
  } command_t;

  typedef struct {
    logic [lse_pkg::StatusWidth-1:0] status;
    lse_pkg::value_t                 value;
    logic [lse_pkg::CountWidth-1:0]  count;
    logic                            empty;
    logic                            last;
  } stack_result_t;

  logic clk;
  logic rst;

  lse_in_if  cmd_if ();
  lse_out_if res_if ();

  lifo_stack_engine #(
    .STACK_DEPTH(DEPTH)
  ) uut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if),
    .res (res_if)
  );

  always #5 clk = ~clk;

  command_t      cmd_queue[$];
  stack_result_t result_queue[$];

  // Shadow copy of the stack that the expected results are computed from.
  lse_pkg::value_t                shadow_stack[DEPTH];
  logic [lse_pkg::CountWidth-1:0] shadow_count;

  int  gen_depth;
  int  cmd_total;
  int  pressure_at;
  int  cmds_taken;
  int  results_checked;
  int  mismatches;
  int  peak_depth;
  int  refused_pushes;
  int  op_seen[4];
  bit  cmd_fire;
  int  send_gap;
  int  stall_left;
  int  hold_left;
  bit  hold_done;

  function automatic bit quiet_phase();
    return cmds_taken >= cmd_total - QUIET_TAIL;
  endfunction

  function automatic lse_pkg::value_t pick_value();
    case ($urandom_range(0, 11))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return lse_pkg::value_t'($urandom);
    endcase
  endfunction

  task automatic add_command(input logic [lse_pkg::OpWidth-1:0] op,
                             input lse_pkg::value_t value);
    command_t c;
    c.op    = op;
    c.value = value;
    cmd_queue.push_back(c);
    if (op == lse_pkg::OP_PUSH && gen_depth < DEPTH) gen_depth++;
    if (op == lse_pkg::OP_POP && gen_depth > 0) gen_depth--;
  endtask

  task automatic add_mixed(input int n, input int push_pct);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < push_pct) add_command(lse_pkg::OP_PUSH, pick_value());
      else if (r < 85) add_command(lse_pkg::OP_POP, pick_value());
      else if (r < 93) add_command(lse_pkg::OP_PEEK, pick_value());
      else add_command(lse_pkg::OP_DUMP, pick_value());
    end
  endtask

  task automatic queue_result(input logic [lse_pkg::StatusWidth-1:0] status,
                              input lse_pkg::value_t value, input logic last);
    stack_result_t r;
    r.status = status;
    r.value  = value;
    r.count  = shadow_count;
    r.empty  = (shadow_count == 0);
    r.last   = last;
    result_queue.push_back(r);
  endtask

  task automatic apply_command(input logic [lse_pkg::OpWidth-1:0] op,
                               input lse_pkg::value_t value);
    op_seen[op]++;
    if (op == lse_pkg::OP_PUSH) begin
      if (shadow_count >= DEPTH) begin
        refused_pushes++;
        queue_result(lse_pkg::ST_FULL, '0, 1'b1);
      end else begin
        shadow_stack[shadow_count] = value;
        shadow_count++;
        queue_result(lse_pkg::ST_OK, '0, 1'b1);
      end
    end else if (shadow_count == 0) begin
      queue_result(lse_pkg::ST_EMPTY, '0, 1'b1);
    end else begin
      case (op)
        lse_pkg::OP_POP: begin
          shadow_count--;
          queue_result(lse_pkg::ST_OK, shadow_stack[shadow_count], 1'b1);
        end
        lse_pkg::OP_PEEK: queue_result(lse_pkg::ST_OK, shadow_stack[shadow_count-1], 1'b1);
        lse_pkg::OP_DUMP: begin
          for (int i = shadow_count; i > 0; i--) begin
            queue_result(lse_pkg::ST_OK, shadow_stack[i-1], i == 1);
          end
        end
        default: begin
        end
      endcase
    end
    if (shadow_count > peak_depth) peak_depth = shadow_count;
  endtask

  // Command side: the transfer is seen at the rising edge, the next offer goes out
  // at the falling edge.
  always @(posedge clk) begin
    cmd_fire = cmd_if.valid && cmd_if.ready && !rst;
    if (cmd_fire) begin
      apply_command(cmd_queue[0].op, cmd_queue[0].value);
      void'(cmd_queue.pop_front());
      cmds_taken++;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      cmd_if.valid <= 1'b0;
    end else if (cmd_fire || !cmd_if.valid) begin
      if (send_gap > 0) begin
        send_gap--;
        cmd_if.valid <= 1'b0;
      end else if (cmd_queue.size() == 0) begin
        cmd_if.valid <= 1'b0;
      end else if (!quiet_phase() && $urandom_range(0, 6) == 0) begin
        send_gap = $urandom_range(0, 8);
        cmd_if.valid <= 1'b0;
      end else begin
        cmd_if.valid      <= 1'b1;
        cmd_if.op         <= cmd_queue[0].op;
        cmd_if.push_value <= cmd_queue[0].value;
      end
    end
  end

  // Result side. Once the full-stack dump is due, the receiver holds off long
  // enough for the block to stall its command input.
  always @(negedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      res_if.ready <= 1'b0;
    end else if (!hold_done && cmds_taken >= pressure_at) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      res_if.ready <= 1'b0;
    end else if (quiet_phase()) begin
      res_if.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      res_if.ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 8);
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    stack_result_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (result_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("[%0t] result with nothing pending: status %0d value %0d count %0d",
                   $realtime, res_if.status, res_if.entry_value, res_if.entry_count);
        end
      end else begin
        want = result_queue.pop_front();
        results_checked++;
        if (res_if.status !== want.status || res_if.entry_value !== want.value ||
            res_if.entry_count !== want.count || res_if.is_empty !== want.empty ||
            res_if.last_of_run !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("[%0t] result %0d mismatch", $realtime, results_checked);
            $display("  expected: status %0d value %0d count %0d empty %0b last %0b",
                     want.status, want.value, want.count, want.empty, want.last);
            $display("  actual:   status %0d value %0d count %0d empty %0b last %0b",
                     res_if.status, res_if.entry_value, res_if.entry_count,
                     res_if.is_empty, res_if.last_of_run);
          end
        end
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("Timeout: no transfer on either channel for %0d cycles", STALL_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    clk               = 1'b0;
    rst               = 1'b1;
    cmd_if.valid      = 1'b0;
    cmd_if.op         = lse_pkg::OP_PUSH;
    cmd_if.push_value = '0;
    res_if.ready      = 1'b0;
    shadow_count      = '0;
    gen_depth         = 0;
    cmds_taken        = 0;
    results_checked   = 0;
    mismatches        = 0;
    peak_depth        = 0;
    refused_pushes    = 0;
    op_seen           = '{default: 0};
    cmd_fire          = 1'b0;
    send_gap          = 0;
    stall_left        = 0;
    hold_left         = 0;
    hold_done         = 1'b0;

    // Empty-stack cases, then the value extremes, then pops back down past empty.
    add_command(lse_pkg::OP_POP, 32'h1234_5678);
    add_command(lse_pkg::OP_PEEK, '0);
    add_command(lse_pkg::OP_DUMP, 32'hFFFF_FFFF);
    add_command(lse_pkg::OP_PUSH, 32'h8000_0000);
    add_command(lse_pkg::OP_PUSH, 32'h7FFF_FFFF);
    add_command(lse_pkg::OP_PUSH, 32'h0000_0000);
    add_command(lse_pkg::OP_PUSH, 32'hFFFF_FFFF);
    add_command(lse_pkg::OP_PUSH, 32'h5555_5555);
    add_command(lse_pkg::OP_PUSH, 32'hAAAA_AAAA);
    add_command(lse_pkg::OP_PEEK, '0);
    add_command(lse_pkg::OP_DUMP, '0);
    add_command(lse_pkg::OP_POP, '0);
    add_command(lse_pkg::OP_POP, '0);
    add_command(lse_pkg::OP_PEEK, '0);
    for (int i = 0; i < 4; i++) add_command(lse_pkg::OP_POP, '0);
    add_command(lse_pkg::OP_POP, '0);
    add_command(lse_pkg::OP_PUSH, 32'h0000_007B);
    add_command(lse_pkg::OP_DUMP, '0);
    add_command(lse_pkg::OP_POP, '0);

    // Random part: a push-heavy mix, a fill past full with a full dump, then a
    // pop-heavy mix that walks the depth back down.
    add_mixed(25, 65);
    while (gen_depth < DEPTH) add_command(lse_pkg::OP_PUSH, pick_value());
    for (int i = 0; i < 3; i++) add_command(lse_pkg::OP_PUSH, pick_value());
    pressure_at = cmd_queue.size();
    add_command(lse_pkg::OP_DUMP, pick_value());
    add_command(lse_pkg::OP_PEEK, pick_value());
    add_mixed(30, 20);
    cmd_total = cmd_queue.size();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (cmd_queue.size() != 0 || result_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Ran %0d commands: %0d push (%0d refused on a full stack), %0d pop,",
             cmd_total, op_seen[lse_pkg::OP_PUSH], refused_pushes, op_seen[lse_pkg::OP_POP]);
    $display("  %0d peek, %0d dump", op_seen[lse_pkg::OP_PEEK], op_seen[lse_pkg::OP_DUMP]);
    $display("Checked %0d results; peak depth %0d of %0d; %0d-cycle result stall; %0d mismatches",
             results_checked, peak_depth, DEPTH, HOLD_CYCLES, mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
